// ===== design/sirs_pkg.sv =====
// Shared types, constants and helpers for the signed integer to radix symbol converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package sirs_pkg;

    localparam int unsigned MaxRadix   = 16;
    localparam int unsigned RadixW     = 5;
    localparam int unsigned DigitW     = 4;
    localparam int unsigned NumW       = 32;
    localparam int unsigned SymW       = 8;
    localparam int unsigned CfgW       = 64;
    localparam int unsigned MaxDigits  = 32;
    localparam int unsigned DigitIdxW  = 5;
    localparam int unsigned DigitCntW  = 6;

    localparam logic [SymW-1:0] SignMinus = 8'h2D;
    localparam logic [SymW-1:0] SignPlus  = 8'h2B;

    // Configuration register indexes
    localparam logic [1:0] CfgRadix    = 2'd0;
    localparam logic [1:0] CfgSymLower = 2'd1;
    localparam logic [1:0] CfgSymUpper = 2'd2;

    localparam logic [RadixW-1:0] RadixReset  = 5'd10;
    localparam logic [CfgW-1:0]   SymLowReset = 64'd4050765991979987505;
    localparam logic [CfgW-1:0]   SymUpReset  = 64'd14648;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    // Pick one symbol byte out of the two packed tables
    function automatic logic [SymW-1:0] sym_at(
        input logic [CfgW-1:0]   lo,
        input logic [CfgW-1:0]   hi,
        input logic [DigitW-1:0] idx
    );
        logic [5:0] sh;
        sh = {idx[2:0], 3'b000};
        return idx[3] ? hi[sh +: SymW] : lo[sh +: SymW];
    endfunction

    // Radix in range, no sign characters among the symbols in use, no repeats
    function automatic logic base_ok(
        input logic [RadixW-1:0] r,
        input logic [CfgW-1:0]   lo,
        input logic [CfgW-1:0]   hi
    );
        logic            ok;
        logic [SymW-1:0] si;
        ok = (r >= RadixW'(2)) && (r <= RadixW'(MaxRadix));
        for (int i = 0; i < MaxRadix; i++) begin
            si = sym_at(lo, hi, DigitW'(i));
            if (RadixW'(i) < r) begin
                if (si == SignPlus || si == SignMinus) ok = 1'b0;
                for (int j = i + 1; j < MaxRadix; j++) begin
                    if (RadixW'(j) < r && sym_at(lo, hi, DigitW'(j)) == si) ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== design/sirs_div_step.sv =====
// One byte slice of restoring division by the radix: eight quotient bits per call.
// Depends on sirs_pkg.
`default_nettype none

module sirs_div_step (
    input  wire logic [sirs_pkg::RadixW-1:0] i_radix,
    input  wire logic [sirs_pkg::DigitW-1:0] i_rem,
    input  wire logic [7:0]                  i_byte,
    output logic      [7:0]                  o_quo,
    output logic      [sirs_pkg::DigitW-1:0] o_rem
);
    import sirs_pkg::*;

    always_comb begin
        logic [RadixW-1:0] t;
        logic [RadixW-1:0] rem;
        rem = RadixW'(i_rem);
        for (int k = 7; k >= 0; k--) begin
            t = {rem[RadixW-2:0], i_byte[k]};
            if (t >= i_radix) begin
                o_quo[k] = 1'b1;
                rem      = t - i_radix;
            end else begin
                o_quo[k] = 1'b0;
                rem      = t;
            end
        end
        o_rem = rem[DigitW-1:0];
    end

endmodule

`default_nettype wire

// ===== design/signed_int_to_radix_symbols_core.sv =====
// Top level of the signed integer to radix symbol converter.
// Depends on sirs_pkg and sirs_div_step.
//
// Usage:
// - Input channel (i_valid / o_stall, payload i_number): one signed 32-bit
//   request is taken when i_valid is high and o_stall is low. o_stall is low
//   only while the block is idle; the output register may still hold the
//   final symbol of the previous number at that time.
// - Output channel (o_valid / i_stall, payload o_symbol, o_last): one byte
//   per transfer, '-' first for a negative number, then digits most
//   significant first; o_last marks the final symbol.
// - Configuration port (i_cfg_we, i_cfg_index, i_cfg_data): radix, symbols
//   0..7 and symbols 8..15. Write only while idle. An invalid base makes a
//   request vanish without output.
// - Timing: the shared divider slice handles one byte of the magnitude per
//   cycle, so each digit takes a pass over every byte of the magnitude,
//   most significant first. After the division the symbols are emitted
//   (sign included), and the emit sequence pauses while the receiver stalls.
// - Stall: while i_stall holds the output register, hold the symbol and
//   pause the emit sequence; nothing is dropped.
// - Reset (i_rst_n low, synchronous): return to idle, clear o_valid and
//   restore radix 10 with the default symbol table (which is invalid
//   until rewritten, as it repeats a symbol).
`default_nettype none

module signed_int_to_radix_symbols_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input request channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [sirs_pkg::NumW-1:0] i_number,
    // Output symbol channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [sirs_pkg::SymW-1:0]     o_symbol,
    output logic                               o_last,
    // Configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [sirs_pkg::CfgW-1:0]     i_cfg_data
);
    import sirs_pkg::*;

    // Configuration registers
    logic [RadixW-1:0] r_radix;
    logic [CfgW-1:0]   r_sym_lo;
    logic [CfgW-1:0]   r_sym_hi;

    // Sequencer and datapath state
    t_state               r_state, n_state;
    logic [NumW-1:0]      r_mag, n_mag;
    logic [23:0]          r_quo, n_quo;
    logic [DigitW-1:0]    r_rem, n_rem;
    logic [1:0]           r_byte_sel, n_byte_sel;
    logic [DigitCntW-1:0] r_nd, n_nd;
    logic                 r_neg, n_neg;
    logic [DigitW-1:0]    r_digits [MaxDigits];

    // Output register
    logic                 r_out_valid, n_out_valid;
    logic [SymW-1:0]      r_out_symbol, n_out_symbol;
    logic                 r_out_last, n_out_last;

    logic                 w_digit_we;
    logic [7:0]           w_byte;
    logic [7:0]           w_qbyte;
    logic [DigitW-1:0]    w_rem;
    logic [NumW-1:0]      w_raw;
    logic [NumW-1:0]      w_quo_full;
    logic [DigitCntW-1:0] w_nd_m1;
    logic                 w_load;

    assign w_raw      = NumW'(i_number);
    assign w_quo_full = {r_quo, w_qbyte};
    assign w_nd_m1    = r_nd - DigitCntW'(1);
    assign w_load     = !r_out_valid || !i_stall;

    // Select the magnitude byte for this slice, most significant first
    always_comb begin
        case (r_byte_sel)
            2'd0:    w_byte = r_mag[31:24];
            2'd1:    w_byte = r_mag[23:16];
            2'd2:    w_byte = r_mag[15:8];
            default: w_byte = r_mag[7:0];
        endcase
    end

    sirs_div_step u_div (
        .i_radix (r_radix),
        .i_rem   (r_rem),
        .i_byte  (w_byte),
        .o_quo   (w_qbyte),
        .o_rem   (w_rem)
    );

    // Configuration writes; out-of-range indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= RadixReset;
            r_sym_lo <= SymLowReset;
            r_sym_hi <= SymUpReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgRadix:    r_radix  <= i_cfg_data[RadixW-1:0];
                CfgSymLower: r_sym_lo <= i_cfg_data;
                CfgSymUpper: r_sym_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_mag        = r_mag;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_byte_sel   = r_byte_sel;
        n_nd         = r_nd;
        n_neg        = r_neg;
        n_out_valid  = r_out_valid && i_stall;
        n_out_symbol = r_out_symbol;
        n_out_last   = r_out_last;
        w_digit_we   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                // Take a request; drop it silently if the base is invalid
                if (i_valid && base_ok(r_radix, r_sym_lo, r_sym_hi)) begin
                    n_neg      = w_raw[NumW-1];
                    n_mag      = w_raw[NumW-1] ? (NumW'(0) - w_raw) : w_raw;
                    n_nd       = '0;
                    n_rem      = '0;
                    n_byte_sel = '0;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem      = w_rem;
                n_quo      = w_quo_full[23:0];
                n_byte_sel = r_byte_sel + 2'd1;
                if (r_byte_sel == 2'd3) begin
                    // Digit complete: store remainder, carry on with the quotient
                    w_digit_we = 1'b1;
                    n_nd       = r_nd + DigitCntW'(1);
                    n_mag      = w_quo_full;
                    n_rem      = '0;
                    if (w_quo_full == '0 || r_nd == DigitCntW'(MaxDigits - 1)) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    if (r_neg) begin
                        n_out_symbol = SignMinus;
                        n_out_last   = 1'b0;
                        n_neg        = 1'b0;
                    end else begin
                        n_out_symbol = sym_at(r_sym_lo, r_sym_hi,
                                              r_digits[w_nd_m1[DigitIdxW-1:0]]);
                        n_out_last   = (r_nd == DigitCntW'(1));
                        n_nd         = w_nd_m1;
                        if (r_nd == DigitCntW'(1)) n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag        <= n_mag;
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_byte_sel   <= n_byte_sel;
        r_nd         <= n_nd;
        r_neg        <= n_neg;
        r_out_symbol <= n_out_symbol;
        r_out_last   <= n_out_last;
        if (w_digit_we) r_digits[r_nd[DigitIdxW-1:0]] <= w_rem;
    end

    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_symbol = r_out_symbol;
    assign o_last   = r_out_last;

endmodule

`default_nettype wire

// ===== design/sirs_checker.sv =====
// Port-level checks for the signed integer to radix symbol converter, bound to its top level.
// Depends on sirs_pkg and signed_int_to_radix_symbols_core.
`default_nettype none

module sirs_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_stall,
    input wire logic                      o_valid,
    input wire logic                      i_stall,
    input wire logic [sirs_pkg::SymW-1:0] o_symbol,
    input wire logic                      o_last
);
    import sirs_pkg::*;

    // A stalled symbol holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_symbol) && $stable(o_last))
        else $error("stalled symbol changed");

    // The sign never ends a number
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_symbol == SignMinus |-> !o_last)
        else $error("minus sign flagged as last");

    // While a number is still being emitted, refuse new requests
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_stall)
        else $error("request accepted mid-number");

    // Symbols of one number follow without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid)
        else $error("gap inside a number");

endmodule

bind signed_int_to_radix_symbols_core sirs_checker u_sirs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_symbol (o_symbol),
    .o_last   (o_last)
);

`default_nettype wire
